/* rtl/spq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants, codes and controller/datapath link types for the
// sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

   // default queue depth
   localparam int DEPTH_DEFAULT = 8;

   // fixed field widths
   localparam int DATA_W   = 32;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;
   localparam int HELD_W   = 4;

   // request modes
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LIST   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd3;

   // datapath operations on the cell row
   localparam int OP_W = 2;
   localparam logic [OP_W-1:0] OP_NONE   = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
   localparam logic [OP_W-1:0] OP_ROTATE = 2'd3;

   // controller to datapath commands
   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic                list_start;
      logic                load_rsp;
      logic [STATUS_W-1:0] rsp_status;
      logic                rsp_last;
      logic                sel_head;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic empty;
      logic full;
      logic list_last;
   } stat_type;

endpackage

/* rtl/spq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// Controller: request decode, list sequencing and response valid handshake.
// ----------------------------------------------------------------------------
module spq_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [spq_pkg::MODE_W-1:0]  req_mode,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output spq_pkg::cmd_type            cmd,
   input  spq_pkg::stat_type           stat
);
   import spq_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_LIST = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic req_take;

   // output register may be loaded when empty or drained this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff == ST_LIST) || !out_free;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   // command decode
   always_comb begin
      state_in       = state_ff;
      cmd.op         = OP_NONE;
      cmd.list_start = 1'b0;
      cmd.load_rsp   = 1'b0;
      cmd.rsp_status = STATUS_OK;
      cmd.rsp_last   = 1'b1;
      cmd.sel_head   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               unique case (req_mode)
                  MODE_INSERT: begin
                     cmd.load_rsp = 1'b1;
                     if (stat.full) begin
                        cmd.rsp_status = STATUS_OVERFLOW;
                     end else begin
                        cmd.op = OP_INSERT;
                     end
                  end
                  MODE_REMOVE: begin
                     cmd.load_rsp = 1'b1;
                     if (stat.empty) begin
                        cmd.rsp_status = STATUS_UNDERFLOW;
                     end else begin
                        cmd.op       = OP_REMOVE;
                        cmd.sel_head = 1'b1;
                     end
                  end
                  MODE_LIST: begin
                     if (stat.empty) begin
                        cmd.load_rsp   = 1'b1;
                        cmd.rsp_status = STATUS_EMPTY;
                     end else begin
                        cmd.list_start = 1'b1;
                        state_in       = ST_LIST;
                     end
                  end
                  MODE_UNUSED: begin
                     // dropped without a response
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LIST: begin
            // emit the head and rotate it to the tail of the held entries
            if (out_free) begin
               cmd.op       = OP_ROTATE;
               cmd.load_rsp = 1'b1;
               cmd.sel_head = 1'b1;
               cmd.rsp_last = stat.list_last;
               if (stat.list_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response valid
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/spq_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_dpath
// Datapath: row of sorted cells with compare-and-shift insert, shift remove,
// rotate for listing, occupancy and list counters, response payload register.
// ----------------------------------------------------------------------------
module spq_dpath #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  spq_pkg::cmd_type                    cmd,
   output spq_pkg::stat_type                   stat,
   input  logic signed [spq_pkg::DATA_W-1:0]   req_value,
   output logic [spq_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [spq_pkg::DATA_W-1:0]   rsp_result_value,
   output logic                                rsp_last,
   output logic [spq_pkg::HELD_W-1:0]          rsp_held
);
   import spq_pkg::*;

   localparam int OCC_W = $clog2(DEPTH + 1);

   logic signed [DATA_W-1:0] entries_ff [DEPTH];
   logic signed [DATA_W-1:0] entries_in [DEPTH];
   logic [DEPTH-1:0]         gt;
   logic [OCC_W-1:0]         occ_ff, occ_in;
   logic [OCC_W-1:0]         cnt_ff, cnt_in;
   logic [OCC_W+HELD_W-1:0]  held_ext;

   logic [STATUS_W-1:0]      status_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic                     last_ff;
   logic [HELD_W-1:0]        held_ff;

   // per-cell compare against the incoming value
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         gt[i] = (OCC_W'(i) < occ_ff) && (entries_ff[i] > req_value);
      end
   end

   // per-cell next value
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         entries_in[i] = entries_ff[i];
      end
      unique case (cmd.op)
         OP_INSERT: begin
            for (int i = 0; i < DEPTH; i++) begin
               if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
                  entries_in[i] = entries_ff[(i > 0) ? i - 1 : 0];
               end else if (gt[i] || OCC_W'(i) == occ_ff) begin
                  entries_in[i] = req_value;
               end
            end
         end
         OP_REMOVE: begin
            for (int i = 0; i < DEPTH - 1; i++) begin
               entries_in[i] = entries_ff[i + 1];
            end
         end
         OP_ROTATE: begin
            for (int i = 0; i < DEPTH; i++) begin
               if (OCC_W'(i + 1) == occ_ff) begin
                  entries_in[i] = entries_ff[0];
               end else if (OCC_W'(i + 1) < occ_ff) begin
                  entries_in[i] = entries_ff[(i < DEPTH - 1) ? i + 1 : i];
               end
            end
         end
         OP_NONE: begin
         end
         default: begin
         end
      endcase
   end

   // occupancy and list counters
   always_comb begin
      occ_in = occ_ff;
      cnt_in = cnt_ff;
      unique case (cmd.op)
         OP_INSERT: occ_in = occ_ff + 1'b1;
         OP_REMOVE: occ_in = occ_ff - 1'b1;
         OP_ROTATE: cnt_in = cnt_ff + 1'b1;
         OP_NONE:   begin
         end
         default:   begin
         end
      endcase
      if (cmd.list_start) begin
         cnt_in = '0;
      end
   end

   assign stat.empty     = (occ_ff == '0);
   assign stat.full      = (occ_ff == OCC_W'(DEPTH));
   assign stat.list_last = (OCC_W'(cnt_ff + 1'b1) == occ_ff);

   // held count is the low bits of the new occupancy
   assign held_ext = {{HELD_W{1'b0}}, occ_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
         cnt_ff <= '0;
      end else begin
         occ_ff <= occ_in;
         cnt_ff <= cnt_in;
      end
   end

   // cell row and response payload
   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         entries_ff[i] <= entries_in[i];
      end
      if (cmd.load_rsp) begin
         status_ff <= cmd.rsp_status;
         value_ff  <= cmd.sel_head ? entries_ff[0] : '0;
         last_ff   <= cmd.rsp_last;
         held_ff   <= held_ext[HELD_W-1:0];
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_result_value = value_ff;
   assign rsp_last         = last_ff;
   assign rsp_held         = held_ff;

endmodule

/* rtl/sorted_priority_queue_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Bounded priority queue holding signed values in ascending order.
// ----------------------------------------------------------------------------
//   channel  dir  handshake              payload
//   req_     in   req_valid / req_stall  req_mode, req_value
//   rsp_     out  rsp_valid / rsp_stall  rsp_status, rsp_result_value,
//                                        rsp_last, rsp_held
//
// insert and remove: the cell row compares and shifts in parallel; a new request
// is taken in the cycle the previous response leaves.
// list: once started, one response per cycle for each held entry unless stalled,
// set by the head-to-tail rotation of the cell row; requests stall meanwhile.
// reset is synchronous and empties the queue; no clearing pass is needed.
// a stalled response holds and back-pressures the request side.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [spq_pkg::MODE_W-1:0]          req_mode,
   input  logic signed [spq_pkg::DATA_W-1:0]   req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [spq_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [spq_pkg::DATA_W-1:0]   rsp_result_value,
   output logic                                rsp_last,
   output logic [spq_pkg::HELD_W-1:0]          rsp_held
);
   import spq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // controller
   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   // datapath
   spq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_value        (req_value),
      .rsp_status       (rsp_status),
      .rsp_result_value (rsp_result_value),
      .rsp_last         (rsp_last),
      .rsp_held         (rsp_held)
   );

endmodule

/* rtl/spq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [spq_pkg::STATUS_W-1:0]        rsp_status,
   input logic signed [spq_pkg::DATA_W-1:0]   rsp_result_value,
   input logic                                rsp_last,
   input logic [spq_pkg::HELD_W-1:0]          rsp_held
);
   import spq_pkg::*;

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_result_value) && $stable(rsp_last) && $stable(rsp_held))
      else $error("stalled response changed");

   // no request is taken while a response is held back
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> !(req_valid && !req_stall))
      else $error("request taken while response stalled");

   // no response straight out of reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   // error responses are single and end the request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_last && rsp_result_value == '0)
      else $error("error response not last or carries a value");

   // underflow and empty only when nothing is held
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_UNDERFLOW || rsp_status == STATUS_EMPTY)
         |-> rsp_held == '0)
      else $error("underflow or empty with entries held");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_result_value (rsp_result_value),
   .rsp_last         (rsp_last),
   .rsp_held         (rsp_held)
);
